>>> sv/bsbp_pkg.sv
// Package with the shared types and constants of the BMP black pixel parser.
`timescale 1ns / 1ps

package bsbp_pkg;

   // Default image limits, used as parameter defaults on the top level.
   localparam int DEF_MAX_WIDTH  = 4096;
   localparam int DEF_MAX_HEIGHT = 4096;

   // Header layout.
   localparam logic [7:0] SIG_B      = 8'h42;
   localparam logic [7:0] SIG_M      = 8'h4D;
   localparam logic [5:0] HDR_SIG0   = 6'd0;
   localparam logic [5:0] HDR_SIG1   = 6'd1;
   localparam logic [5:0] HDR_W_LO   = 6'd18;
   localparam logic [5:0] HDR_W_HI   = 6'd21;
   localparam logic [5:0] HDR_H_LO   = 6'd22;
   localparam logic [5:0] HDR_H_HI   = 6'd25;
   localparam logic [5:0] HDR_DEPTH  = 6'd28;
   localparam logic [5:0] HDR_LAST   = 6'd53;
   localparam logic [7:0] BPP_24     = 8'd24;
   localparam logic [7:0] BPP_32     = 8'd32;

   // Result status codes.
   localparam logic [1:0] ST_PIXEL   = 2'd0;
   localparam logic [1:0] ST_BAD_SIG = 2'd1;
   localparam logic [1:0] ST_DEPTH   = 2'd2;
   localparam logic [1:0] ST_SIZE    = 2'd3;

   typedef enum logic [1:0] {
      PH_HEADER,
      PH_PIXELS,
      PH_PAD,
      PH_IDLE
   } phase_type;

   typedef struct packed {
      logic [1:0]  status;
      logic        is_black;
      logic [11:0] column;
      logic [11:0] row;
      logic        last_pixel;
   } result_type;

endpackage

>>> sv/bsbp_parse.sv
// Parse state and per-byte update logic of the BMP black pixel parser.
`timescale 1ns / 1ps

module bsbp_parse import bsbp_pkg::*; #(
   parameter int MAX_WIDTH  = DEF_MAX_WIDTH,
   parameter int MAX_HEIGHT = DEF_MAX_HEIGHT
) (
   input  logic       clock,
   input  logic       reset,
   input  logic       step,
   input  logic [7:0] data_byte,
   input  logic       file_start,
   output logic       res_valid,
   output result_type res
);

   localparam int COL_W = $clog2(MAX_WIDTH + 1);
   localparam int ROW_W = $clog2(MAX_HEIGHT + 1);

   phase_type        phase_ff, phase_in;
   logic [5:0]       hcnt_ff, hcnt_in;
   logic [31:0]      width_ff, width_in;
   logic [31:0]      height_ff, height_in;
   logic [7:0]       bpp_ff, bpp_in;
   logic [1:0]       bip_ff, bip_in;
   logic             black_ff, black_in;
   logic [COL_W-1:0] col_ff, col_in;
   logic [ROW_W-1:0] row_ff, row_in;
   logic [1:0]       pad_ff, pad_in;

   // A file start restarts from the reset state before this byte is used.
   phase_type        cur_phase;
   logic [5:0]       cur_hcnt;
   logic [31:0]      cur_width, cur_height;
   logic [7:0]       cur_bpp;
   logic [1:0]       cur_bip, cur_pad, lane;
   logic             cur_black;
   logic [COL_W-1:0] cur_col, col_inc;
   logic [ROW_W-1:0] cur_row, row_inc;
   logic [31:0]      col_ext, row_ext;

   logic bad_sig, depth_bad, size_bad, hdr_end, pix_done, col_wrap, row_wrap;

   assign cur_phase  = file_start ? PH_HEADER : phase_ff;
   assign cur_hcnt   = file_start ? '0 : hcnt_ff;
   assign cur_width  = file_start ? '0 : width_ff;
   assign cur_height = file_start ? '0 : height_ff;
   assign cur_bpp    = file_start ? '0 : bpp_ff;
   assign cur_bip    = file_start ? '0 : bip_ff;
   assign cur_black  = file_start ? 1'b0 : black_ff;
   assign cur_col    = file_start ? '0 : col_ff;
   assign cur_row    = file_start ? '0 : row_ff;
   assign cur_pad    = file_start ? '0 : pad_ff;

   assign bad_sig   = ((cur_hcnt == HDR_SIG0) && (data_byte != SIG_B)) ||
                      ((cur_hcnt == HDR_SIG1) && (data_byte != SIG_M));
   assign hdr_end   = (cur_hcnt == HDR_LAST);
   assign depth_bad = (cur_bpp != BPP_24) && (cur_bpp != BPP_32);
   assign size_bad  = (cur_width > 32'(MAX_WIDTH)) || (cur_height > 32'(MAX_HEIGHT));
   assign pix_done  = (cur_bpp == BPP_24) ? (cur_bip >= 2'd2) : (cur_bip == 2'd3);
   assign col_inc   = cur_col + 1'b1;
   assign row_inc   = cur_row + 1'b1;
   assign col_wrap  = 32'(col_inc) >= cur_width;
   assign row_wrap  = 32'(row_inc) >= cur_height;
   assign col_ext   = 32'(cur_col);
   assign row_ext   = 32'(cur_row);
   // Offsets 18 and 22 both have 2 in their low bits.
   assign lane      = cur_hcnt[1:0] - 2'd2;

   // Next phase.
   always_comb begin
      phase_in = cur_phase;
      case (cur_phase)
         PH_HEADER: begin
            if (bad_sig) begin
               phase_in = PH_IDLE;
            end else if (hdr_end) begin
               if (!depth_bad && !size_bad && (cur_width != '0) && (cur_height != '0)) begin
                  phase_in = PH_PIXELS;
               end else begin
                  phase_in = PH_IDLE;
               end
            end
         end
         PH_PIXELS: begin
            if (pix_done && col_wrap) begin
               if (row_wrap) begin
                  phase_in = PH_IDLE;
               end else if (cur_width[1:0] != 2'd0 && cur_bpp == BPP_24) begin
                  phase_in = PH_PAD;
               end
            end
         end
         PH_PAD: begin
            if (cur_pad <= 2'd1) begin
               phase_in = PH_PIXELS;
            end
         end
         default: phase_in = cur_phase;
      endcase
   end

   // Datapath registers and result.
   always_comb begin
      hcnt_in   = cur_hcnt;
      width_in  = cur_width;
      height_in = cur_height;
      bpp_in    = cur_bpp;
      bip_in    = cur_bip;
      black_in  = cur_black;
      col_in    = cur_col;
      row_in    = cur_row;
      pad_in    = cur_pad;
      res_valid = 1'b0;
      res       = '0;
      case (cur_phase)
         PH_HEADER: begin
            if (bad_sig) begin
               res_valid  = 1'b1;
               res.status = ST_BAD_SIG;
            end else begin
               hcnt_in = cur_hcnt + 1'b1;
               if (cur_hcnt >= HDR_W_LO && cur_hcnt <= HDR_W_HI) begin
                  width_in[{lane, 3'b000} +: 8] = data_byte;
               end else if (cur_hcnt >= HDR_H_LO && cur_hcnt <= HDR_H_HI) begin
                  height_in[{lane, 3'b000} +: 8] = data_byte;
               end else if (cur_hcnt == HDR_DEPTH) begin
                  bpp_in = data_byte;
               end
               if (hdr_end && depth_bad) begin
                  res_valid  = 1'b1;
                  res.status = ST_DEPTH;
               end else if (hdr_end && size_bad) begin
                  res_valid  = 1'b1;
                  res.status = ST_SIZE;
               end
            end
         end
         PH_PIXELS: begin
            if (cur_bip == 2'd1) begin
               black_in = (data_byte == 8'd0);
            end
            if (!pix_done) begin
               bip_in = cur_bip + 1'b1;
            end else begin
               bip_in         = '0;
               res_valid      = 1'b1;
               res.status     = ST_PIXEL;
               res.is_black   = cur_black;
               res.column     = col_ext[11:0];
               res.row        = row_ext[11:0];
               res.last_pixel = col_wrap && row_wrap;
               col_in         = col_inc;
               if (col_wrap) begin
                  col_in = '0;
                  row_in = row_inc;
                  // Row padding at 24 bpp equals the low two bits of the width.
                  if (cur_bpp == BPP_24) begin
                     pad_in = cur_width[1:0];
                  end
               end
            end
         end
         PH_PAD: begin
            pad_in = (cur_pad <= 2'd1) ? 2'd0 : cur_pad - 2'd1;
         end
         default: res_valid = 1'b0;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         phase_ff  <= PH_HEADER;
         hcnt_ff   <= '0;
         width_ff  <= '0;
         height_ff <= '0;
         bpp_ff    <= '0;
         bip_ff    <= '0;
         black_ff  <= 1'b0;
         col_ff    <= '0;
         row_ff    <= '0;
         pad_ff    <= '0;
      end else if (step) begin
         phase_ff  <= phase_in;
         hcnt_ff   <= hcnt_in;
         width_ff  <= width_in;
         height_ff <= height_in;
         bpp_ff    <= bpp_in;
         bip_ff    <= bip_in;
         black_ff  <= black_in;
         col_ff    <= col_in;
         row_ff    <= row_in;
         pad_ff    <= pad_in;
      end
   end

endmodule

>>> sv/bsbp_out_reg.sv
// Result register that holds one word until the consumer takes it.
`timescale 1ns / 1ps

module bsbp_out_reg import bsbp_pkg::*; (
   input  logic       clock,
   input  logic       reset,
   input  logic       load,
   input  logic       load_valid,
   input  result_type load_data,
   input  logic       out_ready,
   output logic       out_valid,
   output logic       can_load,
   output result_type out_data
);

   logic       valid_ff, valid_in;
   result_type data_ff;

   assign can_load  = !valid_ff || out_ready;
   assign valid_in  = load ? load_valid : (valid_ff && !out_ready);
   assign out_valid = valid_ff;
   assign out_data  = data_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= 1'b0;
      end else begin
         valid_ff <= valid_in;
      end
   end

   always_ff @(posedge clock) begin
      if (load && load_valid) begin
         data_ff <= load_data;
      end
   end

endmodule

>>> sv/bmp_stream_black_pixel_parser_top.sv
// Top level of the BMP stream black pixel parser.
`timescale 1ns / 1ps
// Path: each result word is registered in the result register before the rsp port.
// Throughput: one byte word per cycle; the single-pass parse update sets this figure,
// and the byte channel stalls only while a result word waits and rsp_ready is low.
// Reset: synchronous, active high; the parser returns to the header phase as if a
// new file were starting, and the result register is emptied.

module bmp_stream_black_pixel_parser_top import bsbp_pkg::*; #(
   parameter int MAX_WIDTH  = DEF_MAX_WIDTH,
   parameter int MAX_HEIGHT = DEF_MAX_HEIGHT
) (
   input  logic        clock,
   input  logic        reset,
   input  logic        req_valid,
   output logic        req_ready,
   input  logic [7:0]  req_data_byte,
   input  logic        req_file_start,
   output logic        rsp_valid,
   input  logic        rsp_ready,
   output logic [1:0]  rsp_status,
   output logic        rsp_is_black,
   output logic [11:0] rsp_column,
   output logic [11:0] rsp_row,
   output logic        rsp_last_pixel
);

   // A byte word is taken whenever the result register is empty or is being drained,
   // so the parser stalls only while a finished result waits on the rsp side untaken.
   logic       step;
   logic       res_valid;
   result_type res;
   result_type out_data;

   assign step = req_valid && req_ready;

   // The parser advances its header, pixel and padding counters once per byte word
   // and flags at most one result word for that byte.
   bsbp_parse #(
      .MAX_WIDTH  (MAX_WIDTH),
      .MAX_HEIGHT (MAX_HEIGHT)
   ) u_parse (
      .clock      (clock),
      .reset      (reset),
      .step       (step),
      .data_byte  (req_data_byte),
      .file_start (req_file_start),
      .res_valid  (res_valid),
      .res        (res)
   );

   // The result register parts the two channels.
   bsbp_out_reg u_out (
      .clock      (clock),
      .reset      (reset),
      .load       (step),
      .load_valid (res_valid),
      .load_data  (res),
      .out_ready  (rsp_ready),
      .out_valid  (rsp_valid),
      .can_load   (req_ready),
      .out_data   (out_data)
   );

   assign rsp_status     = out_data.status;
   assign rsp_is_black   = out_data.is_black;
   assign rsp_column     = out_data.column;
   assign rsp_row        = out_data.row;
   assign rsp_last_pixel = out_data.last_pixel;

   // Error words carry no pixel information.
   a_error_fields_zero: assert property (@(posedge clock) disable iff (reset)
      (rsp_valid && rsp_status != ST_PIXEL) |->
         (!rsp_is_black && rsp_column == 12'd0 && rsp_row == 12'd0 && !rsp_last_pixel))
      else $error("error result word carries pixel fields");

   // With the result register empty the byte channel must be open.
   a_ready_when_empty: assert property (@(posedge clock) disable iff (reset)
      !rsp_valid |-> req_ready)
      else $error("byte channel stalled with empty result register");

   // Reset leaves no result word pending.
   a_reset_empties: assert property (@(posedge clock) disable iff (reset)
      $past(reset) |-> !rsp_valid)
      else $error("result word present right after reset");

endmodule

>>> tb/sv/bmp_stream_black_pixel_parser_top_test.sv
// Self-checking testbench for the BMP stream black pixel parser top level.
`timescale 1ns / 1ps

module bmp_stream_black_pixel_parser_top_test;
   import bsbp_pkg::*;

   // One byte word as the sender offers it.
   typedef struct {
      logic [7:0] data;
      logic       starts_file;
   } byte_word_type;

   // Ways a generated file can break its signature.
   typedef enum int {
      FAULT_NONE,
      FAULT_FIRST,
      FAULT_SECOND
   } sig_fault_type;

   localparam int HDR_BYTES     = 54;
   localparam int HOLDOFF_TICKS = 400;
   localparam int DRAIN_TICKS   = 8;

   logic        clock          = 1'b0;
   logic        reset          = 1'b1;
   logic        req_valid      = 1'b0;
   logic        req_ready;
   logic [7:0]  req_data_byte  = 8'h00;
   logic        req_file_start = 1'b0;
   logic        rsp_valid;
   logic        rsp_ready      = 1'b0;
   logic [1:0]  rsp_status;
   logic        rsp_is_black;
   logic [11:0] rsp_column;
   logic [11:0] rsp_row;
   logic        rsp_last_pixel;

   // Byte words waiting to be offered, and expected result words waiting to come back.
   byte_word_type file_bytes_q[$];
   result_type    pixel_results_q[$];

   int   error_count        = 0;
   int   bytes_queued       = 0;
   int   cut_left           = -1;
   int   sender_idle_pct    = 0;
   int   receiver_stall_pct = 0;
   logic rsp_hold           = 1'b0;
   bit   holdoff_armed      = 1'b0;

   // Parser state as the testbench tracks it.
   phase_type   parse_ph;
   int unsigned hdr_idx;
   int unsigned img_w;
   int unsigned img_h;
   int unsigned depth_bits;
   int unsigned byte_idx;
   int unsigned col_n;
   int unsigned row_n;
   int unsigned pad_left;
   bit          green_zero;

   bmp_stream_black_pixel_parser_top dut (
      .clock          (clock),
      .reset          (reset),
      .req_valid      (req_valid),
      .req_ready      (req_ready),
      .req_data_byte  (req_data_byte),
      .req_file_start (req_file_start),
      .rsp_valid      (rsp_valid),
      .rsp_ready      (rsp_ready),
      .rsp_status     (rsp_status),
      .rsp_is_black   (rsp_is_black),
      .rsp_column     (rsp_column),
      .rsp_row        (rsp_row),
      .rsp_last_pixel (rsp_last_pixel)
   );

   always begin
      #5 clock = 1'b1;
      #5 clock = 1'b0;
   end

   // Reset is held at the start and never again.
   initial begin
      repeat (10) @(posedge clock);
      reset <= 1'b0;
   end

   // Hard limit on the run, far beyond the slowest correct run.
   initial begin
      #5_000_000;
      $display("DONE: errors detected");
      $finish;
   end

   // Puts the tracked parser back at the start of a file.
   function automatic void clear_parse();
      parse_ph   = PH_HEADER;
      hdr_idx    = 0;
      img_w      = 0;
      img_h      = 0;
      depth_bits = 0;
      byte_idx   = 0;
      green_zero = 1'b0;
      col_n      = 0;
      row_n      = 0;
      pad_left   = 0;
   endfunction

   // Advances the tracked parser by one accepted byte word. Returns 1 when that
   // byte produces a result word, which is then placed in r.
   function automatic bit parse_byte(input logic [7:0] b, input logic starts_file,
                                     output result_type r);
      int unsigned idx;
      int unsigned bytes_pp;
      int unsigned pad;
      r = '0;
      if (starts_file)
         clear_parse();
      case (parse_ph)
         PH_HEADER: begin
            idx = hdr_idx;
            // A broken signature is flagged once and the rest of the file is dropped.
            if ((idx == HDR_SIG0 && b != SIG_B) || (idx == HDR_SIG1 && b != SIG_M)) begin
               parse_ph = PH_IDLE;
               r.status = ST_BAD_SIG;
               return 1'b1;
            end
            if (idx >= HDR_W_LO && idx <= HDR_W_HI)
               img_w |= 32'(b) << (8 * (idx - HDR_W_LO));
            else if (idx >= HDR_H_LO && idx <= HDR_H_HI)
               img_h |= 32'(b) << (8 * (idx - HDR_H_LO));
            else if (idx == HDR_DEPTH)
               depth_bits = b;
            hdr_idx = idx + 1;
            if (idx != HDR_LAST)
               return 1'b0;
            parse_ph = PH_IDLE;
            // The depth is judged before the size.
            if (depth_bits != BPP_24 && depth_bits != BPP_32) begin
               r.status = ST_DEPTH;
               return 1'b1;
            end
            if (img_w > DEF_MAX_WIDTH || img_h > DEF_MAX_HEIGHT) begin
               r.status = ST_SIZE;
               return 1'b1;
            end
            if (img_w != 0 && img_h != 0)
               parse_ph = PH_PIXELS;
            return 1'b0;
         end
         PH_PIXELS: begin
            bytes_pp = depth_bits / 8;
            if (byte_idx == 1)
               green_zero = (b == 8'h00);
            if (byte_idx + 1 < bytes_pp) begin
               byte_idx++;
               return 1'b0;
            end
            byte_idx    = 0;
            r.status    = ST_PIXEL;
            r.is_black  = green_zero;
            r.column    = 12'(col_n);
            r.row       = 12'(row_n);
            col_n++;
            if (col_n >= img_w) begin
               col_n = 0;
               row_n++;
               pad = (depth_bits == BPP_24) ? ((4 - ((img_w * 3) & 3)) & 3) : 0;
               if (row_n >= img_h) begin
                  r.last_pixel = 1'b1;
                  parse_ph     = PH_IDLE;
               end else if (pad != 0) begin
                  pad_left = pad;
                  parse_ph = PH_PAD;
               end
            end
            return 1'b1;
         end
         PH_PAD: begin
            if (pad_left <= 1) begin
               pad_left = 0;
               parse_ph = PH_PIXELS;
            end else begin
               pad_left--;
            end
            return 1'b0;
         end
         default: return 1'b0;
      endcase
   endfunction

   task automatic report_mismatch(input string what);
      error_count++;
      if (error_count <= 100)
         $display("%0t: result word mismatch, %s", $time, what);
   endtask

   // Sender. The expected result of a byte is worked out at the edge where the
   // byte is taken, and a new word is offered only once the old one is gone.
   always @(posedge clock) begin : drive_bytes
      result_type    got;
      byte_word_type nxt;
      if (reset) begin
         req_valid <= 1'b0;
         clear_parse();
      end else begin
         if (req_valid && req_ready) begin
            if (parse_byte(req_data_byte, req_file_start, got))
               pixel_results_q.push_back(got);
         end
         if (!req_valid || req_ready) begin
            if (file_bytes_q.size() != 0 && $urandom_range(99) >= sender_idle_pct) begin
               nxt            = file_bytes_q.pop_front();
               req_valid      <= 1'b1;
               req_data_byte  <= nxt.data;
               req_file_start <= nxt.starts_file;
            end else begin
               req_valid <= 1'b0;
            end
         end
      end
   end

   // Receiver. Every result word taken is checked field by field against the
   // oldest expected result word.
   always @(posedge clock) begin : check_results
      result_type want;
      if (reset) begin
         rsp_ready <= 1'b0;
      end else begin
         if (rsp_valid && rsp_ready) begin
            if (pixel_results_q.size() == 0) begin
               report_mismatch($sformatf("word with status %0d while none expected",
                                         rsp_status));
            end else begin
               want = pixel_results_q.pop_front();
               if (rsp_status !== want.status)
                  report_mismatch($sformatf("status %0d, expected %0d",
                                            rsp_status, want.status));
               if (rsp_is_black !== want.is_black)
                  report_mismatch($sformatf("is_black %0d, expected %0d",
                                            rsp_is_black, want.is_black));
               if (rsp_column !== want.column)
                  report_mismatch($sformatf("column %0d, expected %0d",
                                            rsp_column, want.column));
               if (rsp_row !== want.row)
                  report_mismatch($sformatf("row %0d, expected %0d", rsp_row, want.row));
               if (rsp_last_pixel !== want.last_pixel)
                  report_mismatch($sformatf("last_pixel %0d, expected %0d",
                                            rsp_last_pixel, want.last_pixel));
            end
         end
         rsp_ready <= !rsp_hold && ($urandom_range(99) >= receiver_stall_pct);
      end
   end

   // One long stretch with the receiver held off, so that a result word sits in
   // the block and the byte channel backs up behind it.
   initial begin : long_holdoff
      wait (holdoff_armed);
      @(posedge clock);
      rsp_hold <= 1'b1;
      repeat (HOLDOFF_TICKS) @(posedge clock);
      rsp_hold <= 1'b0;
   end

   // Queues one byte word, unless the current file has been cut short.
   task automatic push_byte(input logic [7:0] b, input logic starts_file);
      byte_word_type w;
      if (cut_left == 0)
         return;
      if (cut_left > 0)
         cut_left--;
      w.data        = b;
      w.starts_file = starts_file;
      file_bytes_q.push_back(w);
      bytes_queued++;
   endtask

   // Queues a whole file: a 54-byte header with the given geometry and depth,
   // then pixel rows with their padding when the header is acceptable, then
   // trailing junk. A nonzero cut_len stops the file after that many bytes, so
   // the next file restarts the parse in the middle.
   task automatic send_file(input logic [31:0] w, input logic [31:0] h,
                            input logic [7:0] depth, input sig_fault_type fault,
                            input int cut_len, input int trail_len, input bit flag);
      logic [7:0] hdr [0:HDR_BYTES-1];
      logic [7:0] v;
      int         hdr_len;
      int         bytes_pp;
      int         pad;
      bit         body;
      for (int i = 0; i < HDR_BYTES; i++)
         hdr[i] = 8'($urandom);
      hdr[HDR_SIG0] = SIG_B;
      hdr[HDR_SIG1] = SIG_M;
      for (int k = 0; k < 4; k++) begin
         hdr[HDR_W_LO + k] = w[8*k +: 8];
         hdr[HDR_H_LO + k] = h[8*k +: 8];
      end
      hdr[HDR_DEPTH] = depth;
      hdr_len = HDR_BYTES;
      if (fault == FAULT_FIRST) begin
         do v = 8'($urandom); while (v == SIG_B);
         hdr[HDR_SIG0] = v;
         hdr_len = 1;
      end else if (fault == FAULT_SECOND) begin
         do v = 8'($urandom); while (v == SIG_M);
         hdr[HDR_SIG1] = v;
         hdr_len = 2;
      end
      cut_left = (cut_len > 0) ? cut_len : -1;
      for (int i = 0; i < hdr_len; i++)
         push_byte(hdr[i], flag && i == 0);
      body = fault == FAULT_NONE && (depth == BPP_24 || depth == BPP_32) &&
             w <= DEF_MAX_WIDTH && h <= DEF_MAX_HEIGHT;
      if (body) begin
         bytes_pp = depth / 8;
         pad      = (depth == BPP_24) ? ((4 - ((w * 3) % 4)) % 4) : 0;
         for (int y = 0; y < h; y++) begin
            for (int x = 0; x < w; x++) begin
               for (int k = 0; k < bytes_pp; k++) begin
                  // The green byte is zero about half of the time.
                  if (k == 1)
                     push_byte($urandom_range(1) ? 8'h00 : 8'($urandom_range(1, 255)), 1'b0);
                  else
                     push_byte(8'($urandom), 1'b0);
               end
            end
            for (int k = 0; k < pad; k++)
               push_byte(8'($urandom), 1'b0);
         end
      end
      for (int i = 0; i < trail_len; i++)
         push_byte(8'($urandom), 1'b0);
      cut_left = -1;
   endtask

   // Mostly well-formed small images with random content; the rest are broken
   // signatures, bad depths, oversize or empty images, cut files and junk.
   task automatic send_random_file();
      logic [31:0]   w;
      logic [31:0]   h;
      logic [7:0]    depth;
      sig_fault_type fault;
      int            kind;
      int            cut;
      int            trail;
      bit            flag;
      kind  = $urandom_range(99);
      w     = ($urandom_range(9) == 0) ? $urandom_range(7, 20) : $urandom_range(1, 6);
      h     = $urandom_range(1, 4);
      depth = $urandom_range(1) ? BPP_24 : BPP_32;
      fault = FAULT_NONE;
      cut   = 0;
      trail = ($urandom_range(7) == 0) ? $urandom_range(1, 5) : 0;
      flag  = ($urandom_range(24) != 0);
      if (kind < 6) begin
         fault = $urandom_range(1) ? FAULT_FIRST : FAULT_SECOND;
      end else if (kind < 11) begin
         depth = 8'($urandom);
         if (depth == BPP_24 || depth == BPP_32)
            depth = 8'h00;
      end else if (kind < 16) begin
         if ($urandom_range(1))
            w = DEF_MAX_WIDTH + 1 + $urandom_range(3);
         else
            h = $urandom | 32'h0000_2000;
      end else if (kind < 20) begin
         if ($urandom_range(1))
            w = 0;
         else
            h = 0;
      end else if (kind < 27) begin
         cut = $urandom_range(1, 90);
      end
      send_file(w, h, depth, fault, cut, trail, flag);
   endtask

   // Holds the sender back until every queued word is taken and every expected
   // result word has arrived.
   task automatic wait_idle();
      do @(negedge clock);
      while (file_bytes_q.size() != 0 || req_valid || pixel_results_q.size() != 0);
   endtask

   initial begin : stimulus
      int idle_pct  [0:3];
      int stall_pct [0:3];
      int target;

      idle_pct  = '{0, 51, 0, 31};
      stall_pct = '{0, 0, 51, 31};

      // Directed files, sent without idling. The first one has no file flag:
      // after reset the parser already expects a header.
      send_file(2, 2, BPP_24, FAULT_NONE, 0, 0, 1'b0);
      send_file(1, 1, BPP_32, FAULT_NONE, 0, 0, 1'b1);
      // Row padding of three, one and zero bytes.
      send_file(3, 2, BPP_24, FAULT_NONE, 0, 0, 1'b1);
      send_file(1, 3, BPP_24, FAULT_NONE, 0, 0, 1'b1);
      send_file(4, 2, BPP_24, FAULT_NONE, 0, 0, 1'b1);
      // Junk after the last pixel is ignored.
      send_file(2, 2, BPP_32, FAULT_NONE, 0, 4, 1'b1);
      send_file(2, 2, BPP_24, FAULT_FIRST, 0, 3, 1'b1);
      send_file(2, 2, BPP_24, FAULT_SECOND, 0, 3, 1'b1);
      send_file(2, 2, 8'd8, FAULT_NONE, 0, 2, 1'b1);
      send_file(2, 2, 8'd0, FAULT_NONE, 0, 0, 1'b1);
      send_file(2, 2, 8'd255, FAULT_NONE, 0, 0, 1'b1);
      // A bad depth wins over an oversize width.
      send_file(5000, 2, 8'd16, FAULT_NONE, 0, 0, 1'b1);
      send_file(DEF_MAX_WIDTH + 1, 1, BPP_32, FAULT_NONE, 0, 2, 1'b1);
      send_file(1, DEF_MAX_HEIGHT + 1, BPP_24, FAULT_NONE, 0, 0, 1'b1);
      // Negative sizes read as huge unsigned values.
      send_file(32'h8000_0000, 1, BPP_24, FAULT_NONE, 0, 0, 1'b1);
      send_file(1, 32'hFFFF_FFFF, BPP_32, FAULT_NONE, 0, 0, 1'b1);
      // Empty images give no result at all.
      send_file(0, 3, BPP_24, FAULT_NONE, 0, 3, 1'b1);
      send_file(3, 0, BPP_32, FAULT_NONE, 0, 0, 1'b1);
      // Restarts in the middle of the header, the pixels and the padding.
      send_file(3, 2, BPP_24, FAULT_NONE, 20, 0, 1'b1);
      send_file(3, 2, BPP_24, FAULT_NONE, 58, 0, 1'b1);
      send_file(3, 2, BPP_24, FAULT_NONE, 64, 0, 1'b1);
      wait_idle();

      // Receiver held off while the sender keeps two files coming.
      holdoff_armed = 1'b1;
      send_file(6, 4, BPP_32, FAULT_NONE, 0, 0, 1'b1);
      send_file(5, 3, BPP_24, FAULT_NONE, 0, 0, 1'b1);

      // Random files under each idling pattern, with the occasional pause until
      // the block has drained.
      for (int p = 0; p < 4; p++) begin
         wait_idle();
         sender_idle_pct    = idle_pct[p];
         receiver_stall_pct = stall_pct[p];
         target             = bytes_queued + 20;
         while (bytes_queued < target) begin
            send_random_file();
            if ($urandom_range(11) == 0)
               wait_idle();
         end
      end

      wait_idle();
      repeat (DRAIN_TICKS) @(posedge clock);
      if (error_count == 0)
         $display("DONE: 0 errors");
      else
         $display("DONE: errors detected");
      $finish;
   end

endmodule
